// ===== hdl/aes256_cbc_cipher_unit_defines.svh =====
// Assertion macros shared by the AES-256 CBC unit.
`ifndef AES256_CBC_CIPHER_UNIT_DEFINES_SVH
`define AES256_CBC_CIPHER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define AC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("aes256 cbc unit check failed");

// Next-cycle implication, checked out of reset.
`define AC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("aes256 cbc unit check failed");

`endif

// ===== hdl/aescbc_pkg.sv =====
// Types, constants and round functions of the AES-256 CBC unit.
package aescbc_pkg;

  localparam int unsigned NumRounds = 14;
  localparam int unsigned NumWords  = 60;
  localparam int unsigned NumRows   = NumWords / 4;
  localparam logic [4:0]  BlkBytes  = 5'd16;

  typedef enum logic [2:0] {
    CFG_KEY0  = 3'd0,
    CFG_KEY1  = 3'd1,
    CFG_KEY2  = 3'd2,
    CFG_KEY3  = 3'd3,
    CFG_IV_HI = 3'd4,
    CFG_IV_LO = 3'd5,
    CFG_MODE  = 3'd6,
    CFG_NONE  = 3'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_PREP,
    ST_RUN,
    ST_DONE
  } back_state_t;

  typedef struct packed {
    logic [127:0] data;
    logic         first;
    logic         last;
    logic         dec;
  } job_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] REV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xt(logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [127:0] sub_bytes(logic [127:0] s, logic inv);
    logic [127:0] o;
    for (int k = 0; k < 16; k++) begin
      o[8*k +: 8] = inv ? REV_SBOX[s[8*k +: 8]] : SBOX[s[8*k +: 8]];
    end
    return o;
  endfunction

  // Byte n of the block sits at bits 127-8n downward.
  function automatic logic [127:0] shift_rows(logic [127:0] s, logic inv);
    logic [127:0] o;
    int src;
    int dst;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = 4 * ((c + r) & 3) + r;
        dst = 4 * c + r;
        if (inv) o[127 - 8*src -: 8] = s[127 - 8*dst -: 8];
        else     o[127 - 8*dst -: 8] = s[127 - 8*src -: 8];
      end
    end
    return o;
  endfunction

  function automatic logic [127:0] mix_cols(logic [127:0] s, logic inv);
    logic [127:0] o;
    logic [7:0] a [4];
    logic [7:0] a2 [4];
    logic [7:0] a4 [4];
    logic [7:0] a8 [4];
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        a[k]  = s[127 - 8*(4*c + k) -: 8];
        a2[k] = xt(a[k]);
        a4[k] = xt(a2[k]);
        a8[k] = xt(a4[k]);
      end
      for (int r = 0; r < 4; r++) begin
        if (inv) begin
          o[127 - 8*(4*c + r) -: 8] =
            (a8[r] ^ a4[r] ^ a2[r]) ^
            (a8[(r+1)&3] ^ a2[(r+1)&3] ^ a[(r+1)&3]) ^
            (a8[(r+2)&3] ^ a4[(r+2)&3] ^ a[(r+2)&3]) ^
            (a8[(r+3)&3] ^ a[(r+3)&3]);
        end else begin
          o[127 - 8*(4*c + r) -: 8] =
            a2[r] ^ (a2[(r+1)&3] ^ a[(r+1)&3]) ^ a[(r+2)&3] ^ a[(r+3)&3];
        end
      end
    end
    return o;
  endfunction

endpackage

// ===== hdl/aescbc_in_if.sv =====
// Input block channel of the AES-256 CBC unit.
interface aescbc_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_high;
  logic [63:0] data_low;
  logic [4:0]  byte_count;
  logic        first_block;
  logic        last_block;

  modport source (output valid, data_high, data_low, byte_count, first_block, last_block,
                  input ready);
  modport sink   (input valid, data_high, data_low, byte_count, first_block, last_block,
                  output ready);
endinterface

// ===== hdl/aescbc_out_if.sv =====
// Result block channel of the AES-256 CBC unit.
interface aescbc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_high;
  logic [63:0] out_low;
  logic [4:0]  valid_bytes;
  logic        out_last;
  logic        pad_error;

  modport source (output valid, out_high, out_low, valid_bytes, out_last, pad_error,
                  input ready);
  modport sink   (input valid, out_high, out_low, valid_bytes, out_last, pad_error,
                  output ready);
endinterface

// ===== hdl/aescbc_cfg_if.sv =====
// Configuration write channel of the AES-256 CBC unit.
interface aescbc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/aescbc_front.sv =====
// Front end: accept blocks; to encrypt, pad and split a full last block in two jobs.
module aescbc_front (
  input  logic                 clk,
  input  logic                 rst_n,
  aescbc_in_if.sink            in_chan,
  input  logic                 decrypt_mode,
  output logic                 job_valid,
  output aescbc_pkg::job_t     job,
  input  logic                 job_ready
);

  logic       pad_pend_r;
  logic       pad_pend_nxt;
  logic [4:0] cnt;
  logic [7:0] pad_byte;
  logic       full_last;
  aescbc_pkg::job_t in_job;

  assign in_chan.ready = job_ready && !pad_pend_r;
  assign cnt      = (in_chan.byte_count > aescbc_pkg::BlkBytes) ? aescbc_pkg::BlkBytes
                                                                 : in_chan.byte_count;
  assign pad_byte = {3'b000, aescbc_pkg::BlkBytes - cnt};
  assign full_last = !decrypt_mode && in_chan.last_block && (cnt == aescbc_pkg::BlkBytes);

  always_comb begin
    in_job.data  = {in_chan.data_high, in_chan.data_low};
    in_job.first = in_chan.first_block;
    in_job.dec   = decrypt_mode;
    in_job.last  = in_chan.last_block && !full_last;
    // Fill the tail of a short last block with the pad length.
    if (!decrypt_mode && in_chan.last_block) begin
      for (int k = 0; k < 16; k++) begin
        if (5'(k) >= cnt) in_job.data[127 - 8*k -: 8] = pad_byte;
      end
    end
  end

  always_comb begin
    if (pad_pend_r) begin
      job_valid  = 1'b1;
      job.data   = {16{8'h10}};
      job.first  = 1'b0;
      job.last   = 1'b1;
      job.dec    = 1'b0;
    end else begin
      job_valid  = in_chan.valid;
      job        = in_job;
    end
  end

  always_comb begin
    pad_pend_nxt = pad_pend_r;
    if (pad_pend_r && job_ready) pad_pend_nxt = 1'b0;
    else if (in_chan.valid && in_chan.ready && full_last) pad_pend_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) pad_pend_r <= 1'b0;
    else        pad_pend_r <= pad_pend_nxt;
  end

endmodule

// ===== hdl/aescbc_queue.sv =====
// Two-entry job queue between front end and cipher engine.
module aescbc_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  input  aescbc_pkg::job_t wr_job,
  output logic             wr_ready,
  output logic             rd_valid,
  output aescbc_pkg::job_t rd_job,
  input  logic             rd_pop
);

  aescbc_pkg::job_t slot_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_job   = slot_r[rp_r];
  assign push     = wr_valid && wr_ready;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = rd_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, rd_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= wr_job;
  end

endmodule

// ===== hdl/aescbc_engine.sv =====
// Back end: key expansion, round engine, CBC chaining and result register.
module aescbc_engine (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [255:0]     key,
  input  logic [127:0]     iv,
  input  logic             key_wr,
  input  logic             job_valid,
  input  aescbc_pkg::job_t job,
  output logic             job_pop,
  aescbc_out_if.source     out_chan
);

  aescbc_pkg::back_state_t state_r, state_nxt;

  logic [127:0] rk_mem [aescbc_pkg::NumRows];
  logic [127:0] rk_q;
  logic [3:0]   rd_addr;
  logic         rk_we;
  logic [3:0]   rk_waddr;
  logic [127:0] rk_wdata;

  logic         stale_r;
  logic [5:0]   wi_r, wi_nxt;
  logic [31:0]  win_r [8];
  logic [31:0]  rowbuf_r [3];
  logic [7:0]   rc_r, rc_nxt;
  logic [31:0]  w_new;
  logic [31:0]  t_w;

  logic [3:0]   step_r, step_nxt;
  logic [3:0]   step_up;
  logic [127:0] s_r, xor_r, chain_r;
  logic         dec_r, last_r;
  logic [127:0] cv;
  logic [127:0] rnd;
  logic [127:0] res;
  logic [4:0]   vb_r;
  logic         err_r;
  logic [7:0]   pbyte;
  logic         out_free;

  logic         out_valid_r;
  logic [127:0] out_data_r;
  logic [4:0]   out_vb_r;
  logic         out_last_r;
  logic         out_err_r;

  assign out_free = !out_valid_r || out_chan.ready;
  assign cv       = job.first ? iv : chain_r;
  assign step_up  = (step_r == 4'(aescbc_pkg::NumRounds)) ? step_r : step_r + 4'd1;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      aescbc_pkg::ST_IDLE:
        if (job_valid) state_nxt = stale_r ? aescbc_pkg::ST_EXPAND : aescbc_pkg::ST_PREP;
      aescbc_pkg::ST_EXPAND:
        if (wi_r == 6'(aescbc_pkg::NumWords - 1)) state_nxt = aescbc_pkg::ST_IDLE;
      aescbc_pkg::ST_PREP:
        state_nxt = aescbc_pkg::ST_RUN;
      aescbc_pkg::ST_RUN:
        if (step_r == 4'(aescbc_pkg::NumRounds)) state_nxt = aescbc_pkg::ST_DONE;
      aescbc_pkg::ST_DONE:
        if (out_free) state_nxt = aescbc_pkg::ST_IDLE;
      default:
        state_nxt = aescbc_pkg::ST_IDLE;
    endcase
  end

  // Key expansion word.
  always_comb begin
    t_w = win_r[7];
    if (wi_r[2:0] == 3'd0) t_w = aescbc_pkg::sub_word({t_w[23:0], t_w[31:24]}) ^ {rc_r, 24'd0};
    else if (wi_r[2:0] == 3'd4) t_w = aescbc_pkg::sub_word(t_w);
    w_new = (wi_r < 6'd8) ? key[255 - 32*wi_r[2:0] -: 32] : (win_r[0] ^ t_w);
  end

  // Round datapath.
  always_comb begin
    if (step_r == 4'd0) begin
      rnd = s_r ^ rk_q;
    end else if (!dec_r) begin
      rnd = aescbc_pkg::shift_rows(aescbc_pkg::sub_bytes(s_r, 1'b0), 1'b0);
      if (step_r != 4'(aescbc_pkg::NumRounds)) rnd = aescbc_pkg::mix_cols(rnd, 1'b0);
      rnd = rnd ^ rk_q;
    end else begin
      rnd = aescbc_pkg::sub_bytes(aescbc_pkg::shift_rows(s_r, 1'b1), 1'b1) ^ rk_q;
      if (step_r != 4'(aescbc_pkg::NumRounds)) rnd = aescbc_pkg::mix_cols(rnd, 1'b1);
    end
    res   = dec_r ? (rnd ^ xor_r) : rnd;
    pbyte = res[7:0];
  end

  // Outputs of the state machine.
  always_comb begin
    job_pop  = 1'b0;
    rk_we    = 1'b0;
    rk_waddr = wi_r[5:2];
    rk_wdata = {rowbuf_r[0], rowbuf_r[1], rowbuf_r[2], w_new};
    wi_nxt   = wi_r;
    rc_nxt   = rc_r;
    step_nxt = step_r;
    rd_addr  = 4'd0;
    case (state_r)
      aescbc_pkg::ST_IDLE: begin
        job_pop = job_valid && !stale_r;
        wi_nxt  = 6'd0;
        rc_nxt  = 8'h01;
      end
      aescbc_pkg::ST_EXPAND: begin
        rk_we  = (wi_r[1:0] == 2'd3);
        wi_nxt = wi_r + 6'd1;
        if (wi_r >= 6'd8 && wi_r[2:0] == 3'd0) rc_nxt = aescbc_pkg::xt(rc_r);
      end
      aescbc_pkg::ST_PREP: begin
        rd_addr  = dec_r ? 4'(aescbc_pkg::NumRounds) : 4'd0;
        step_nxt = 4'd0;
      end
      aescbc_pkg::ST_RUN: begin
        rd_addr  = dec_r ? 4'(aescbc_pkg::NumRounds) - step_up : step_up;
        step_nxt = step_r + 4'd1;
      end
      aescbc_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= aescbc_pkg::ST_IDLE;
      stale_r     <= 1'b1;
      chain_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (key_wr) stale_r <= 1'b1;
      else if (state_r == aescbc_pkg::ST_EXPAND && state_nxt == aescbc_pkg::ST_IDLE)
        stale_r <= 1'b0;
      if (job_pop) begin
        if (job.dec) chain_r <= job.data;
      end else if (state_r == aescbc_pkg::ST_RUN && step_r == 4'(aescbc_pkg::NumRounds)
                   && !dec_r) begin
        chain_r <= rnd;
      end
      if (state_r == aescbc_pkg::ST_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_chan.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    wi_r   <= wi_nxt;
    rc_r   <= rc_nxt;
    step_r <= step_nxt;
    rk_q   <= rk_mem[rd_addr];
    if (rk_we) rk_mem[rk_waddr] <= rk_wdata;
    if (state_r == aescbc_pkg::ST_EXPAND) begin
      for (int j = 0; j < 7; j++) win_r[j] <= win_r[j+1];
      win_r[7] <= w_new;
      if (wi_r[1:0] != 2'd3) rowbuf_r[wi_r[1:0]] <= w_new;
    end
    if (job_pop) begin
      s_r    <= job.dec ? job.data : (job.data ^ cv);
      xor_r  <= cv;
      dec_r  <= job.dec;
      last_r <= job.last;
    end else if (state_r == aescbc_pkg::ST_RUN) begin
      s_r <= (step_r == 4'(aescbc_pkg::NumRounds)) ? res : rnd;
      if (step_r == 4'(aescbc_pkg::NumRounds)) begin
        vb_r  <= aescbc_pkg::BlkBytes;
        err_r <= 1'b0;
        if (dec_r && last_r) begin
          if (pbyte != 8'd0 && pbyte <= {3'b000, aescbc_pkg::BlkBytes})
            vb_r <= aescbc_pkg::BlkBytes - pbyte[4:0];
          else
            err_r <= 1'b1;
        end
      end
    end
    if (state_r == aescbc_pkg::ST_DONE && out_free) begin
      out_data_r <= s_r;
      out_vb_r   <= vb_r;
      out_last_r <= last_r;
      out_err_r  <= err_r;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.out_high    = out_data_r[127:64];
  assign out_chan.out_low     = out_data_r[63:0];
  assign out_chan.valid_bytes = out_vb_r;
  assign out_chan.out_last    = out_last_r;
  assign out_chan.pad_error   = out_err_r;

endmodule

// ===== hdl/aes256_cbc_cipher_unit.sv =====
// AES-256 CBC unit with PKCS#7 padding: top level with configuration registers.
// From acceptance to result a block goes through pop, key fetch, 15 round steps, drain.
// The engine holds one block at a time, set by the single round unit and CBC chaining.
// After reset or any key write, the next block waits for the key expansion.
// A full last encrypt block yields two results, the second one a block of padding.
// Reset (rst_n low, synchronous) clears control, IV, key, mode and the chaining value.
module aes256_cbc_cipher_unit (
  input  logic          clk,
  input  logic          rst_n,
  aescbc_cfg_if.sink    cfg_chan,
  aescbc_in_if.sink     in_chan,
  aescbc_out_if.source  out_chan
);

  `include "aes256_cbc_cipher_unit_defines.svh"

  // Configuration registers; write them only while no block is in flight.
  logic [255:0] key_r;
  logic [127:0] iv_r;
  logic         mode_r;
  logic         cfg_wr;
  logic         key_wr;

  // Front-to-queue and queue-to-engine transactions.
  logic             fq_valid, fq_ready;
  aescbc_pkg::job_t fq_job;
  logic             qe_valid, qe_pop;
  aescbc_pkg::job_t qe_job;

  assign cfg_chan.ready = 1'b1;
  assign cfg_wr = cfg_chan.valid && cfg_chan.ready;
  assign key_wr = cfg_wr && (cfg_chan.index == aescbc_pkg::CFG_KEY0 ||
                             cfg_chan.index == aescbc_pkg::CFG_KEY1 ||
                             cfg_chan.index == aescbc_pkg::CFG_KEY2 ||
                             cfg_chan.index == aescbc_pkg::CFG_KEY3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r  <= '0;
      iv_r   <= '0;
      mode_r <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_chan.index)
        aescbc_pkg::CFG_KEY0:  key_r[255:192] <= cfg_chan.data;
        aescbc_pkg::CFG_KEY1:  key_r[191:128] <= cfg_chan.data;
        aescbc_pkg::CFG_KEY2:  key_r[127:64]  <= cfg_chan.data;
        aescbc_pkg::CFG_KEY3:  key_r[63:0]    <= cfg_chan.data;
        aescbc_pkg::CFG_IV_HI: iv_r[127:64]   <= cfg_chan.data;
        aescbc_pkg::CFG_IV_LO: iv_r[63:0]     <= cfg_chan.data;
        aescbc_pkg::CFG_MODE:  mode_r         <= cfg_chan.data[0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Front end: pad and classify, hold an extra padding block when needed.
  aescbc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_chan      (in_chan),
    .decrypt_mode (mode_r),
    .job_valid    (fq_valid),
    .job          (fq_job),
    .job_ready    (fq_ready)
  );

  // Short queue decouples acceptance from the round engine.
  aescbc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_job   (fq_job),
    .wr_ready (fq_ready),
    .rd_valid (qe_valid),
    .rd_job   (qe_job),
    .rd_pop   (qe_pop)
  );

  // Back end: expand the key when stale, run 15 round steps, advance the chain.
  aescbc_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .key       (key_r),
    .iv        (iv_r),
    .key_wr    (key_wr),
    .job_valid (qe_valid),
    .job       (qe_job),
    .job_pop   (qe_pop),
    .out_chan  (out_chan)
  );

  // A padding error only appears on the last block and reports a full block.
  `AC_ASSERT_IMP(a_err_last, out_chan.valid && out_chan.pad_error, out_chan.out_last)
  `AC_ASSERT_IMP(a_err_full, out_chan.valid && out_chan.pad_error, out_chan.valid_bytes == 5'd16)
  // A short block count is only ever reported on the last result.
  `AC_ASSERT_IMP(a_short_last, out_chan.valid && out_chan.valid_bytes != 5'd16,
                 out_chan.out_last)

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the AES-256 CBC cipher unit with PKCS#7 padding.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
    logic [4:0]  vb;
    logic        last;
    logic        err;
  } cipher_res_t;

  typedef struct packed {
    logic        dec;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [4:0]  cnt;
    logic        first;
    logic        last;
    logic        typed;
    cipher_res_t known;
  } block_row_t;

  logic clk;
  logic rst_n;

  aescbc_cfg_if cfg_chan ();
  aescbc_in_if  in_chan ();
  aescbc_out_if out_chan ();

  aes256_cbc_cipher_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Shadow of the block: registers, chaining value and expanded key schedule.
  logic [63:0] key_reg [4];
  logic [63:0] iv_hi_reg;
  logic [63:0] iv_lo_reg;
  logic        dec_mode;
  logic [127:0] chain;
  logic        sched_stale;
  logic [31:0] sched_words [60];
  logic [7:0]  fwd_sb [256];
  logic [7:0]  rev_sb [256];

  cipher_res_t pending_blocks [$];
  int          fail_count;
  int          idle_phase;   // 0 none, 1 sender idles, 2 receiver stalls, 3 both lightly
  int          items_sent;

  // FIPS-197 AES-256 known answer, and its ciphertext decrypted as a last block: a pad error.
  block_row_t dir_rows [13] = '{
    '{1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff, 5'd16, 1'b0, 1'b0, 1'b1,
      '{64'h8ea2b7ca516745bf, 64'heafc49904b496089, 5'd16, 1'b0, 1'b0}},
    '{1'b0, 64'hffffffffffffffff, 64'hffffffffffffffff, 5'd16, 1'b0, 1'b0, 1'b0, '0},
    '{1'b0, 64'h0, 64'h0, 5'd0, 1'b0, 1'b1, 1'b0, '0},
    '{1'b0, 64'h0123456789abcdef, 64'hfedcba9876543210, 5'd15, 1'b1, 1'b1, 1'b0, '0},
    '{1'b0, 64'hffffffffffffffff, 64'hffffffffffffffff, 5'd16, 1'b1, 1'b1, 1'b0, '0},
    '{1'b0, 64'ha5a5a5a5a5a5a5a5, 64'ha5a5a5a5a5a5a5a5, 5'd31, 1'b0, 1'b1, 1'b0, '0},
    '{1'b0, 64'h5a5a5a5a5a5a5a5a, 64'h5a5a5a5a5a5a5a5a, 5'd3, 1'b1, 1'b0, 1'b0, '0},
    '{1'b0, 64'h0, 64'h0, 5'd1, 1'b0, 1'b1, 1'b0, '0},
    '{1'b1, 64'h8ea2b7ca516745bf, 64'heafc49904b496089, 5'd16, 1'b1, 1'b0, 1'b1,
      '{64'h0011223344556677, 64'h8899aabbccddeeff, 5'd16, 1'b0, 1'b0}},
    '{1'b1, 64'h8ea2b7ca516745bf, 64'heafc49904b496089, 5'd16, 1'b1, 1'b1, 1'b1,
      '{64'h0011223344556677, 64'h8899aabbccddeeff, 5'd16, 1'b1, 1'b1}},
    '{1'b1, 64'hffffffffffffffff, 64'hffffffffffffffff, 5'd5, 1'b0, 1'b0, 1'b0, '0},
    '{1'b1, 64'h0, 64'h0, 5'd0, 1'b1, 1'b1, 1'b0, '0},
    '{1'b1, 64'hffffffffffffffff, 64'hffffffffffffffff, 5'd31, 1'b0, 1'b1, 1'b0, '0}
  };

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------- GF(2^8) and AES rounds

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int k = 0; k < 8; k++) begin
      if (b[0]) acc ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      b = b >> 1;
    end
    return acc;
  endfunction

  function automatic logic [7:0] rotl8(logic [7:0] b, int n);
    return (b << n) | (b >> (8 - n));
  endfunction

  // Build the substitution tables from the field inverse and the affine map.
  function automatic void build_sboxes();
    logic [7:0] inv;
    logic [7:0] s;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h00;
      for (int y = 1; y < 256; y++) begin
        if (gf_mul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
      end
      s = inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3) ^ rotl8(inv, 4) ^ 8'h63;
      fwd_sb[x] = s;
      rev_sb[s] = x[7:0];
    end
  endfunction

  function automatic logic [31:0] sbox_word(logic [31:0] w);
    return {fwd_sb[w[31:24]], fwd_sb[w[23:16]], fwd_sb[w[15:8]], fwd_sb[w[7:0]]};
  endfunction

  function automatic void expand_schedule();
    logic [31:0] t;
    logic [7:0]  rc;
    rc = 8'h01;
    for (int i = 0; i < 8; i++) begin
      sched_words[i] = (i % 2 == 0) ? key_reg[i / 2][63:32] : key_reg[i / 2][31:0];
    end
    for (int i = 8; i < 60; i++) begin
      t = sched_words[i - 1];
      if (i % 8 == 0) begin
        t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = gf_mul(rc, 8'h02);
      end else if (i % 8 == 4) begin
        t = sbox_word(t);
      end
      sched_words[i] = sched_words[i - 8] ^ t;
    end
  endfunction

  function automatic logic [127:0] sched_row(int r);
    return {sched_words[4*r], sched_words[4*r+1], sched_words[4*r+2], sched_words[4*r+3]};
  endfunction

  // Byte n of a block lives at bits 127-8n downward.
  function automatic logic [127:0] subst(logic [127:0] s, bit rev);
    logic [127:0] o;
    for (int n = 0; n < 16; n++) begin
      o[127-8*n -: 8] = rev ? rev_sb[s[127-8*n -: 8]] : fwd_sb[s[127-8*n -: 8]];
    end
    return o;
  endfunction

  function automatic logic [127:0] rotate_rows(logic [127:0] s, bit rev);
    logic [127:0] o;
    int src;
    int dst;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = 4 * ((c + r) % 4) + r;
        dst = 4 * c + r;
        if (rev) o[127-8*src -: 8] = s[127-8*dst -: 8];
        else     o[127-8*dst -: 8] = s[127-8*src -: 8];
      end
    end
    return o;
  endfunction

  function automatic logic [127:0] mix_columns(logic [127:0] s, bit rev);
    logic [127:0] o;
    logic [7:0]   m [4];
    logic [7:0]   acc;
    if (rev) m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
    else     m = '{8'h02, 8'h03, 8'h01, 8'h01};
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        acc = 8'h00;
        for (int k = 0; k < 4; k++) begin
          acc ^= gf_mul(m[(k - r + 4) % 4], s[127-8*(4*c+k) -: 8]);
        end
        o[127-8*(4*c+r) -: 8] = acc;
      end
    end
    return o;
  endfunction

  function automatic logic [127:0] aes_encipher(logic [127:0] s);
    s ^= sched_row(0);
    for (int r = 1; r < 14; r++) begin
      s = mix_columns(rotate_rows(subst(s, 1'b0), 1'b0), 1'b0) ^ sched_row(r);
    end
    return rotate_rows(subst(s, 1'b0), 1'b0) ^ sched_row(14);
  endfunction

  function automatic logic [127:0] aes_decipher(logic [127:0] s);
    s ^= sched_row(14);
    for (int r = 13; r > 0; r--) begin
      s = mix_columns(subst(rotate_rows(s, 1'b1), 1'b1) ^ sched_row(r), 1'b1);
    end
    return subst(rotate_rows(s, 1'b1), 1'b1) ^ sched_row(0);
  endfunction

  function automatic void refresh_schedule();
    if (sched_stale) begin
      expand_schedule();
      sched_stale = 1'b0;
    end
  endfunction

  // Work out the result blocks that one accepted block produces and queue them.
  function automatic void predict_cbc(logic [63:0] hi, logic [63:0] lo, logic [4:0] cnt,
                                      logic first, logic last);
    logic [127:0] blk;
    logic [127:0] prev;
    logic [127:0] plain;
    logic [7:0]   pad;
    int           c;
    refresh_schedule();
    if (first) chain = {iv_hi_reg, iv_lo_reg};
    c = (cnt > 16) ? 16 : cnt;
    blk = {hi, lo};
    if (dec_mode) begin
      prev = chain;
      chain = blk;
      plain = aes_decipher(blk) ^ prev;
      pad = plain[7:0];
      if (last && pad >= 1 && pad <= 16)
        pending_blocks.push_back('{plain[127:64], plain[63:0], 5'(16 - pad), 1'b1, 1'b0});
      else
        pending_blocks.push_back('{plain[127:64], plain[63:0], 5'd16, last, last});
    end else if (!last) begin
      chain = aes_encipher(blk ^ chain);
      pending_blocks.push_back('{chain[127:64], chain[63:0], 5'd16, 1'b0, 1'b0});
    end else if (c < 16) begin
      for (int i = c; i < 16; i++) blk[127-8*i -: 8] = 8'(16 - c);
      chain = aes_encipher(blk ^ chain);
      pending_blocks.push_back('{chain[127:64], chain[63:0], 5'd16, 1'b1, 1'b0});
    end else begin
      // Full last block: an extra block of padding follows.
      chain = aes_encipher(blk ^ chain);
      pending_blocks.push_back('{chain[127:64], chain[63:0], 5'd16, 1'b0, 1'b0});
      chain = aes_encipher({16{8'h10}} ^ chain);
      pending_blocks.push_back('{chain[127:64], chain[63:0], 5'd16, 1'b1, 1'b0});
    end
  endfunction

  // ---------------------------------------------------------------- channel drivers

  function automatic int draw_gap(int pct);
    int gap;
    gap = 0;
    while ($urandom_range(99) < pct && gap < 60) gap++;
    return gap;
  endfunction

  // Offer one block, hold it until accepted, then predict and idle per phase.
  task automatic send_block(logic [63:0] hi, logic [63:0] lo, logic [4:0] cnt,
                            logic first, logic last, logic typed, cipher_res_t known);
    int gap;
    in_chan.valid       <= 1'b1;
    in_chan.data_high   <= hi;
    in_chan.data_low    <= lo;
    in_chan.byte_count  <= cnt;
    in_chan.first_block <= first;
    in_chan.last_block  <= last;
    do @(posedge clk); while (!in_chan.ready);
    predict_cbc(hi, lo, cnt, first, last);
    if (typed) pending_blocks[pending_blocks.size() - 1] = known;
    items_sent++;
    gap = draw_gap(idle_phase == 1 ? 85 : (idle_phase == 3 ? 16 : 0));
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Keep valid high across back-to-back writes; cfg_release drops it.
  task automatic cfg_write(aescbc_pkg::cfg_idx_t idx, logic [63:0] val);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= val;
    do @(posedge clk); while (!cfg_chan.ready);
    case (idx)
      aescbc_pkg::CFG_KEY0:  begin key_reg[0] = val; sched_stale = 1'b1; end
      aescbc_pkg::CFG_KEY1:  begin key_reg[1] = val; sched_stale = 1'b1; end
      aescbc_pkg::CFG_KEY2:  begin key_reg[2] = val; sched_stale = 1'b1; end
      aescbc_pkg::CFG_KEY3:  begin key_reg[3] = val; sched_stale = 1'b1; end
      aescbc_pkg::CFG_IV_HI: iv_hi_reg = val;
      aescbc_pkg::CFG_IV_LO: iv_lo_reg = val;
      aescbc_pkg::CFG_MODE:  dec_mode = val[0];
      default:   ;
    endcase
  endtask

  task automatic cfg_release();
    cfg_chan.valid <= 1'b0;
  endtask

  // Drop the input, drain every expected block, then let the pipeline settle.
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic load_setting(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2,
                              logic [63:0] k3, logic [63:0] ivh, logic [63:0] ivl,
                              logic [63:0] mode);
    drain_results();
    cfg_write(aescbc_pkg::CFG_KEY0, k0);
    cfg_write(aescbc_pkg::CFG_KEY1, k1);
    cfg_write(aescbc_pkg::CFG_KEY2, k2);
    cfg_write(aescbc_pkg::CFG_KEY3, k3);
    cfg_write(aescbc_pkg::CFG_IV_HI, ivh);
    cfg_write(aescbc_pkg::CFG_IV_LO, ivl);
    cfg_write(aescbc_pkg::CFG_MODE, mode);
    // An out-of-range index must leave every register untouched.
    if ($urandom_range(1)) cfg_write(aescbc_pkg::CFG_NONE, {$urandom, $urandom});
    cfg_release();
  endtask

  function automatic logic [4:0] pick_count(logic last);
    if (!last) return 5'($urandom_range(31));
    if ($urandom_range(9) == 0) return 5'($urandom_range(31, 17));
    return 5'($urandom_range(16));
  endfunction

  // Encrypt-mode message: mostly well framed, some with random framing flags.
  task automatic send_encrypt_msg();
    int   n;
    bit   framed;
    logic first;
    logic last;
    framed = ($urandom_range(99) < 80);
    n = $urandom_range(1, 5);
    for (int b = 0; b < n; b++) begin
      first = framed ? (b == 0) : 1'($urandom_range(1));
      last  = framed ? (b == n - 1) : 1'($urandom_range(1));
      send_block({$urandom, $urandom}, {$urandom, $urandom}, pick_count(last),
                 first, last, 1'b0, '0);
    end
  endtask

  // Decrypt-mode message: mostly real padded ciphertext, some corrupted or pure noise.
  task automatic send_decrypt_msg();
    int           n;
    int           kind;
    logic [127:0] lc;
    logic [127:0] pt;
    logic [127:0] ct;
    int           pad;
    kind = $urandom_range(99);
    n = $urandom_range(1, 5);
    refresh_schedule();
    lc = {iv_hi_reg, iv_lo_reg};
    for (int b = 0; b < n; b++) begin
      if (kind < 85) begin
        pt = {$urandom, $urandom, $urandom, $urandom};
        if (b == n - 1) begin
          pad = $urandom_range(1, 16);
          for (int i = 16 - pad; i < 16; i++) pt[127-8*i -: 8] = 8'(pad);
        end
        ct = aes_encipher(pt ^ lc);
        lc = ct;
        // Flip one bit of the last ciphertext now and then to break the padding.
        if (kind >= 75 && b == n - 1) ct[$urandom_range(127)] ^= 1'b1;
        send_block(ct[127:64], ct[63:0], 5'($urandom_range(31)), b == 0, b == n - 1,
                   1'b0, '0);
      end else begin
        send_block({$urandom, $urandom}, {$urandom, $urandom}, 5'($urandom_range(31)),
                   1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0, '0);
      end
    end
  endtask

  // ---------------------------------------------------------------- result checker

  task automatic check_result();
    cipher_res_t exp_blk;
    if (pending_blocks.size() == 0) begin
      $error("unexpected result block %h_%h", out_chan.out_high, out_chan.out_low);
      fail_count++;
    end else begin
      exp_blk = pending_blocks.pop_front();
      if (out_chan.out_high !== exp_blk.hi) begin
        $error("out_high expected %h actual %h", exp_blk.hi, out_chan.out_high);
        fail_count++;
      end
      if (out_chan.out_low !== exp_blk.lo) begin
        $error("out_low expected %h actual %h", exp_blk.lo, out_chan.out_low);
        fail_count++;
      end
      if (out_chan.valid_bytes !== exp_blk.vb) begin
        $error("valid_bytes expected %0d actual %0d", exp_blk.vb, out_chan.valid_bytes);
        fail_count++;
      end
      if (out_chan.out_last !== exp_blk.last) begin
        $error("out_last expected %b actual %b", exp_blk.last, out_chan.out_last);
        fail_count++;
      end
      if (out_chan.pad_error !== exp_blk.err) begin
        $error("pad_error expected %b actual %b", exp_blk.err, out_chan.pad_error);
        fail_count++;
      end
    end
  endtask

  // Sample the transaction on the edge, then redraw ready for the next cycle.
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) check_result();
    out_chan.ready <= ($urandom_range(99) >=
                       (idle_phase == 2 ? 85 : (idle_phase == 3 ? 16 : 0)));
  end

  // ---------------------------------------------------------------- main sequence

  initial begin
    int target;
    in_chan.valid       = 1'b0;
    in_chan.data_high   = '0;
    in_chan.data_low    = '0;
    in_chan.byte_count  = '0;
    in_chan.first_block = 1'b0;
    in_chan.last_block  = 1'b0;
    cfg_chan.valid      = 1'b0;
    cfg_chan.index      = aescbc_pkg::CFG_KEY0;
    cfg_chan.data       = '0;
    out_chan.ready      = 1'b0;
    rst_n               = 1'b0;
    fail_count          = 0;
    idle_phase          = 0;
    items_sent          = 0;

    // Shadow state after reset: everything zero, schedule due for expansion.
    key_reg     = '{default: '0};
    iv_hi_reg   = '0;
    iv_lo_reg   = '0;
    dec_mode    = 1'b0;
    chain       = '0;
    sched_stale = 1'b1;
    build_sboxes();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: standard key 00..1f with a zero IV, encrypt rows then decrypt rows.
    load_setting(64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617,
                 64'h18191a1b1c1d1e1f, 64'h0, 64'h0, 64'h0);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].dec != dec_mode) begin
        drain_results();
        cfg_write(aescbc_pkg::CFG_MODE, {63'h0, dir_rows[i].dec});
        cfg_release();
      end
      send_block(dir_rows[i].hi, dir_rows[i].lo, dir_rows[i].cnt, dir_rows[i].first,
                 dir_rows[i].last, dir_rows[i].typed, dir_rows[i].known);
    end

    // Random part: eight settings, extremes first, rotating through the idling phases.
    for (int s = 0; s < 8; s++) begin
      idle_phase = 0;
      case (s)
        0: load_setting(64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0);
        1: load_setting('1, '1, '1, '1, '1, '1, '1);
        default: load_setting({$urandom, $urandom}, {$urandom, $urandom},
                              {$urandom, $urandom}, {$urandom, $urandom},
                              {$urandom, $urandom}, {$urandom, $urandom},
                              {$urandom, 31'($urandom), 1'(s % 2)});
      endcase
      idle_phase = s % 4;
      target = items_sent + 206;
      while (items_sent < target) begin
        if (dec_mode) send_decrypt_msg();
        else send_encrypt_msg();
        // In setting 5, hold off mid-setting until every outstanding block has come back.
        if (s == 5 && items_sent >= target - 103 && items_sent < target - 97) begin
          in_chan.valid <= 1'b0;
          while (pending_blocks.size() != 0) @(posedge clk);
        end
      end
    end

    idle_phase = 0;
    drain_results();
    if (fail_count == 0) begin
      $display("** aes256_cbc_cipher_unit: PASSED **");
    end else begin
      $display("** aes256_cbc_cipher_unit: FAILED **");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #8_000_000;
    $display("** aes256_cbc_cipher_unit: FAILED **");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/aescbc_pkg.sv
hdl/aescbc_in_if.sv
hdl/aescbc_out_if.sv
hdl/aescbc_cfg_if.sv
hdl/aescbc_front.sv
hdl/aescbc_queue.sv
hdl/aescbc_engine.sv
hdl/aes256_cbc_cipher_unit.sv
tb/testbench.sv
